[design/image_sensor_pin_sequencer_defines.svh]
// Assertion macros shared by the pin sequencer modules.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef IMAGE_SENSOR_PIN_SEQUENCER_DEFINES_SVH
`define IMAGE_SENSOR_PIN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ISPSEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pin sequencer check failed");

// Next-cycle implication, checked out of reset
`define ISPSEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pin sequencer check failed");

`endif

[design/ispseq_pkg.sv]
// Package for the image sensor pin sequencer: widths, phase codes, pin bits,
// register indexes and the config/result structs. No dependencies.
`timescale 1ns / 1ps

package ispseq_pkg;

    localparam int PIXEL_W     = 12;
    localparam int SAMPLE_BITS = 12;
    localparam logic [PIXEL_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} : PIXEL_W'((1 << SAMPLE_BITS) - 1);

    // Input kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_CAPTURE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_REGS_LOW     = 2'd0;
    localparam logic [1:0] CFG_REGS_HIGH    = 2'd1;
    localparam logic [1:0] CFG_STEP_TICKS   = 2'd2;
    localparam logic [1:0] CFG_CAPTURE_MODE = 2'd3;

    localparam logic [31:0] REGS_LOW_RST   = 32'h2000_0380;
    localparam logic [31:0] REGS_HIGH_RST  = 32'h2101_0001;
    localparam logic [7:0]  STEP_TICKS_RST = 8'h0A;

    // Pin bit positions in the pin level vector
    localparam int PIN_CLK   = 0;
    localparam int PIN_RST   = 1;
    localparam int PIN_LOAD  = 2;
    localparam int PIN_START = 3;
    localparam int PIN_SIN   = 4;

    // Sequencer phases
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_LR0     = 5'd1;
    localparam logic [4:0] PH_LR1     = 5'd2;
    localparam logic [4:0] PH_LR2     = 5'd3;
    localparam logic [4:0] PH_LR3     = 5'd4;
    localparam logic [4:0] PH_B0      = 5'd5;
    localparam logic [4:0] PH_B1      = 5'd6;
    localparam logic [4:0] PH_B2      = 5'd7;
    localparam logic [4:0] PH_B3      = 5'd8;
    localparam logic [4:0] PH_S0      = 5'd9;
    localparam logic [4:0] PH_S1      = 5'd10;
    localparam logic [4:0] PH_S2      = 5'd11;
    localparam logic [4:0] PH_S3      = 5'd12;
    localparam logic [4:0] PH_W0      = 5'd13;
    localparam logic [4:0] PH_W1      = 5'd14;
    localparam logic [4:0] PH_W2      = 5'd15;
    localparam logic [4:0] PH_W3_SEEN = 5'd16;
    localparam logic [4:0] PH_W3_NOT  = 5'd17;
    localparam logic [4:0] PH_P0      = 5'd18;
    localparam logic [4:0] PH_P1      = 5'd19;
    localparam logic [4:0] PH_P2      = 5'd20;
    localparam logic [4:0] PH_L0      = 5'd21;
    localparam logic [4:0] PH_L1      = 5'd22;
    localparam logic [4:0] PH_L2      = 5'd23;
    localparam logic [4:0] PH_L3      = 5'd24;
    localparam logic [4:0] PH_F0      = 5'd25;
    localparam logic [4:0] PH_CR0     = 5'd26;
    localparam logic [4:0] PH_CR1     = 5'd27;
    localparam logic [4:0] PH_CR2     = 5'd28;
    localparam logic [4:0] PH_CR3     = 5'd29;

    localparam logic [3:0] LAST_BIT = 4'd10;
    localparam logic [2:0] LAST_REG = 3'd7;

    typedef struct packed {
        logic [31:0] regs_low;
        logic [31:0] regs_high;
        logic [7:0]  step_ticks;
        logic        capture_mode;
    } t_cfg;

    typedef struct packed {
        logic               sensor_clock;
        logic               reset_pin;
        logic               load_pin;
        logic               start_pin;
        logic               serial_data;
        logic               pixel_valid;
        logic [PIXEL_W-1:0] pixel_value;
        logic               busy_res;
        logic               seq_done;
    } t_result;

endpackage

[design/ispseq_cfg.sv]
// Configuration register file for the pin sequencer.
// Depends on ispseq_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module ispseq_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output ispseq_pkg::t_cfg   o_cfg
);
    import ispseq_pkg::*;

    t_cfg r_cfg;

    // Always able to take a write request
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.regs_low     <= REGS_LOW_RST;
            r_cfg.regs_high    <= REGS_HIGH_RST;
            r_cfg.step_ticks   <= STEP_TICKS_RST;
            r_cfg.capture_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REGS_LOW:     r_cfg.regs_low     <= i_cfg_data;
                CFG_REGS_HIGH:    r_cfg.regs_high    <= i_cfg_data;
                CFG_STEP_TICKS:   r_cfg.step_ticks   <= i_cfg_data[7:0];
                CFG_CAPTURE_MODE: r_cfg.capture_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

[design/ispseq_core.sv]
// Sequencer state and per-tick next-state logic of the pin sequencer.
// Depends on ispseq_pkg and image_sensor_pin_sequencer_defines.svh.
`timescale 1ns / 1ps

module ispseq_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [1:0]                       i_kind,
    input  logic                             i_read_level,
    input  logic [ispseq_pkg::PIXEL_W-1:0]   i_pixel_sample,
    input  ispseq_pkg::t_cfg                 i_cfg,
    output ispseq_pkg::t_result              o_result
);
    import ispseq_pkg::*;

    `include "image_sensor_pin_sequencer_defines.svh"

    logic [4:0] r_phase,      n_phase;
    logic [7:0] r_step_count, n_step_count;
    logic [2:0] r_reg_index,  n_reg_index;
    logic [3:0] r_bit_index,  n_bit_index;
    logic [4:0] r_pins,       n_pins;

    logic               emit;
    logic [PIXEL_W-1:0] emit_value;
    logic               done;
    logic [7:0]         step_len;
    logic [7:0]         count_inc;
    logic               cur_bit;
    logic [31:0]        sel_word;
    logic [7:0]         sel_byte;
    logic [3:0]         bit_pos;

    // Serial bit for the current register/bit position: address then data MSB first
    always_comb begin
        sel_word = r_reg_index[2] ? i_cfg.regs_high : i_cfg.regs_low;
        sel_byte = sel_word[{r_reg_index[1:0], 3'b000} +: 8];
        bit_pos  = (r_bit_index <= LAST_BIT) ? (LAST_BIT - r_bit_index) : 4'd0;
        if (r_bit_index < 4'd3) begin
            cur_bit = r_reg_index[2'(4'd2 - r_bit_index)];
        end else begin
            cur_bit = (bit_pos < 4'd8) ? sel_byte[bit_pos[2:0]] : 1'b0;
        end
    end

    assign step_len  = (i_cfg.step_ticks != 8'd0) ? i_cfg.step_ticks : 8'd1;
    assign count_inc = r_step_count + 8'd1;

    // One tick of the sequencer
    always_comb begin
        n_phase      = r_phase;
        n_step_count = r_step_count;
        n_reg_index  = r_reg_index;
        n_bit_index  = r_bit_index;
        n_pins       = r_pins;
        emit         = 1'b0;
        emit_value   = '0;
        done         = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_kind == KIND_LOAD) begin
                n_pins[PIN_CLK] = 1'b0;
                n_pins[PIN_RST] = 1'b0;
                n_phase         = PH_LR0;
                n_step_count    = 8'd0;
            end else if (i_kind == KIND_CAPTURE) begin
                n_pins[PIN_CLK] = 1'b0;
                n_phase         = PH_S0;
                n_step_count    = 8'd0;
            end
        end else begin
            n_step_count = count_inc;
            if (count_inc >= step_len) begin
                n_step_count = 8'd0;
                unique case (r_phase)
                    PH_LR0: n_phase = PH_LR1;
                    PH_LR1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_LR2;
                    end
                    PH_LR2: n_phase = PH_LR3;
                    PH_LR3: begin
                        n_pins[PIN_RST] = 1'b1;
                        n_pins[PIN_CLK] = 1'b0;
                        n_reg_index     = 3'd0;
                        n_bit_index     = 4'd0;
                        n_phase         = PH_B0;
                    end
                    PH_B0: begin
                        if (r_bit_index < 4'd3) begin
                            n_pins[PIN_LOAD] = 1'b0;
                        end
                        n_pins[PIN_SIN] = cur_bit;
                        n_phase         = PH_B1;
                    end
                    PH_B1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_B2;
                    end
                    PH_B2: begin
                        if (r_bit_index >= LAST_BIT) begin
                            n_pins[PIN_LOAD] = 1'b1;
                        end else begin
                            n_pins[PIN_SIN] = 1'b0;
                        end
                        n_phase = PH_B3;
                    end
                    PH_B3: begin
                        if (r_bit_index < LAST_BIT) begin
                            n_bit_index     = r_bit_index + 4'd1;
                            n_pins[PIN_CLK] = 1'b0;
                            n_phase         = PH_B0;
                        end else if (r_reg_index < LAST_REG) begin
                            n_reg_index     = r_reg_index + 3'd1;
                            n_bit_index     = 4'd0;
                            n_pins[PIN_CLK] = 1'b0;
                            n_phase         = PH_B0;
                        end else begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                    PH_S0: begin
                        n_pins[PIN_SIN]   = 1'b0;
                        n_pins[PIN_LOAD]  = 1'b0;
                        n_pins[PIN_START] = 1'b1;
                        n_phase           = PH_S1;
                    end
                    PH_S1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_S2;
                    end
                    PH_S2: begin
                        n_pins[PIN_START] = 1'b0;
                        n_phase           = PH_S3;
                    end
                    PH_S3: begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_phase         = PH_W0;
                    end
                    PH_W0: n_phase = PH_W1;
                    PH_W1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_W2;
                    end
                    PH_W2: n_phase = i_read_level ? PH_W3_SEEN : PH_W3_NOT;
                    PH_W3_SEEN: begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_phase         = PH_P0;
                    end
                    PH_W3_NOT: begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_phase         = PH_W0;
                    end
                    PH_P0: n_phase = PH_P1;
                    PH_P1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_P2;
                    end
                    PH_P2, PH_L3: begin
                        // READ high: one pixel per sensor clock when capture_mode is clear; low: wrap up
                        if (i_read_level) begin
                            n_phase = PH_L0;
                            if (!i_cfg.capture_mode) begin
                                emit       = 1'b1;
                                emit_value = i_pixel_sample & SAMPLE_MASK;
                            end
                        end else begin
                            n_phase = PH_F0;
                        end
                    end
                    PH_L0: begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_phase         = PH_L1;
                    end
                    PH_L1: n_phase = PH_L2;
                    PH_L2: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_L3;
                    end
                    PH_F0: begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_pins[PIN_RST] = 1'b0;
                        n_phase         = PH_CR0;
                    end
                    PH_CR0: n_phase = PH_CR1;
                    PH_CR1: begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_phase         = PH_CR2;
                    end
                    PH_CR2: n_phase = PH_CR3;
                    PH_CR3: begin
                        n_pins[PIN_RST] = 1'b1;
                        n_phase         = PH_IDLE;
                        done            = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // State update, once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_step_count <= 8'd0;
            r_reg_index  <= 3'd0;
            r_bit_index  <= 4'd0;
            r_pins       <= 5'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_step_count <= n_step_count;
            r_reg_index  <= n_reg_index;
            r_bit_index  <= n_bit_index;
            r_pins       <= n_pins;
        end
    end

    // Result of this tick, pins after the update
    always_comb begin
        o_result.sensor_clock = n_pins[PIN_CLK];
        o_result.reset_pin    = n_pins[PIN_RST];
        o_result.load_pin     = n_pins[PIN_LOAD];
        o_result.start_pin    = n_pins[PIN_START];
        o_result.serial_data  = n_pins[PIN_SIN];
        o_result.pixel_valid  = emit;
        o_result.pixel_value  = emit_value;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.seq_done     = done;
    end

    `ISPSEQ_ASSERT_NOW(a_done_not_busy, done, n_phase == PH_IDLE && !emit)
    `ISPSEQ_ASSERT_NOW(a_emit_to_low_clk, emit, n_phase == PH_L0 && !i_cfg.capture_mode)
    `ISPSEQ_ASSERT_NOW(a_bit_in_range, 1'b1, r_bit_index <= LAST_BIT)
    `ISPSEQ_ASSERT_NEXT(a_hold_when_idle_stage, !i_step, $stable(r_phase) && $stable(r_pins))

endmodule

[design/image_sensor_pin_sequencer.sv]
// Image sensor pin sequencer: input tick register, sequencer core, result register.
// Depends on ispseq_pkg, ispseq_cfg, ispseq_core and the defines header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one base tick per request:
//   i_kind (tick, begin load, begin capture), the sampled READ level and a
//   converter sample. Every request yields exactly one result request on the
//   output channel (o_out_valid / i_out_stall) with the sensor pin levels,
//   an optional pixel, busy and done flags.
//   An accepted request is first loaded into the input register, and its
//   result is loaded into the result register once that register is free.
//   Throughput: one tick per cycle while the receiver does not stall, set by
//   the combinational next-state logic of the sequencer core.
//   Configuration writes go over i_cfg_valid / o_cfg_ready with an index and
//   32-bit data; ready is always high. Write only while the block is idle.
//   Reset (synchronous, active low) returns the sequencer to idle with all
//   pins low and loads the register defaults.
//   When the receiver stalls, the result register holds its value and the
//   input register still takes one more request before o_in_stall rises.
`timescale 1ns / 1ps

module image_sensor_pin_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic                             i_read_level,
    input  logic [ispseq_pkg::PIXEL_W-1:0]   i_pixel_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_sensor_clock,
    output logic                             o_reset_pin,
    output logic                             o_load_pin,
    output logic                             o_start_pin,
    output logic                             o_serial_data,
    output logic                             o_pixel_valid,
    output logic [ispseq_pkg::PIXEL_W-1:0]   o_pixel_value,
    output logic                             o_busy_res,
    output logic                             o_seq_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import ispseq_pkg::*;

    `include "image_sensor_pin_sequencer_defines.svh"

    logic               r_in_valid;
    logic [1:0]         r_in_kind;
    logic               r_in_read;
    logic [PIXEL_W-1:0] r_in_sample;
    logic               r_out_valid;
    t_result            r_out;

    t_cfg    cfg;
    t_result core_result;
    logic    out_free;
    logic    in_ready;
    logic    proc;

    // Handshake: result register frees when empty or taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign in_ready   = !r_in_valid || out_free;
    assign o_in_stall = !in_ready;

    ispseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ispseq_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (proc),
        .i_kind         (r_in_kind),
        .i_read_level   (r_in_read),
        .i_pixel_sample (r_in_sample),
        .i_cfg          (cfg),
        .o_result       (core_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_kind   <= i_kind;
            r_in_read   <= i_read_level;
            r_in_sample <= i_pixel_sample;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sensor_clock = r_out.sensor_clock;
    assign o_reset_pin    = r_out.reset_pin;
    assign o_load_pin     = r_out.load_pin;
    assign o_start_pin    = r_out.start_pin;
    assign o_serial_data  = r_out.serial_data;
    assign o_pixel_valid  = r_out.pixel_valid;
    assign o_pixel_value  = r_out.pixel_value;
    assign o_busy_res     = r_out.busy_res;
    assign o_seq_done     = r_out.seq_done;

    `ISPSEQ_ASSERT_NOW(a_stall_means_full, o_in_stall, r_in_valid && r_out_valid)
    `ISPSEQ_ASSERT_NEXT(a_proc_fills_out, proc, r_out_valid)
    `ISPSEQ_ASSERT_NEXT(a_held_result, r_out_valid && i_out_stall, r_out_valid && $stable(r_out))

endmodule
